[src/pr_cc_pkg.sv]
// Shared types and constants of the proportional-resonant current controller.
`timescale 1ns / 1ps

package pr_cc_pkg;

   localparam int CsrIndexWidth = 8;
   localparam int DutyWidth     = 16;
   localparam int ResWidth      = 32;
   localparam int MulBWidth     = 33;
   localparam int ResFracShift  = 16;
   localparam int PropShift     = 12;
   localparam int InAlignShift  = 4;
   localparam int DutyShift     = 17;
   localparam int KdcResetValue = 65536;

   localparam logic [CsrIndexWidth-1:0] RegPropGain     = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] RegResGain      = CsrIndexWidth'(1);
   localparam logic [CsrIndexWidth-1:0] RegResFeedback  = CsrIndexWidth'(2);
   localparam logic [CsrIndexWidth-1:0] RegOutputScale  = CsrIndexWidth'(3);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_RG,
      S_MUL_RF,
      S_MUL_KP,
      S_RES,
      S_MUL_KDC,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_RES_GAIN,
      MUL_RES_FB,
      MUL_PROP,
      MUL_SCALE
   } mul_op_type;

   typedef struct packed {
      logic       capture;
      mul_op_type mul_op;
      logic       acc_init;
      logic       acc_add;
      logic       res_update;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

endpackage

[src/pr_cc_ctrl.sv]
// Sequencing state machine of the proportional-resonant current controller.
`timescale 1ns / 1ps

module pr_cc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  pr_cc_pkg::status_type  status,
   output pr_cc_pkg::cmd_type     cmd
);
   import pr_cc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd.capture    = 1'b0;
      cmd.mul_op     = MUL_NONE;
      cmd.acc_init   = 1'b0;
      cmd.acc_add    = 1'b0;
      cmd.res_update = 1'b0;
      cmd.out_load   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_MUL_RG;
            end
         end
         S_MUL_RG: begin
            cmd.mul_op = MUL_RES_GAIN;
            state_in   = S_MUL_RF;
         end
         S_MUL_RF: begin
            cmd.mul_op   = MUL_RES_FB;
            cmd.acc_init = 1'b1;
            state_in     = S_MUL_KP;
         end
         S_MUL_KP: begin
            cmd.mul_op  = MUL_PROP;
            cmd.acc_add = 1'b1;
            state_in    = S_RES;
         end
         S_RES: begin
            cmd.res_update = 1'b1;
            state_in       = S_MUL_KDC;
         end
         S_MUL_KDC: begin
            cmd.mul_op = MUL_SCALE;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[src/pr_cc_dp.sv]
// Datapath of the proportional-resonant current controller: gains, delay line, shared multiplier.
`timescale 1ns / 1ps

module pr_cc_dp #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 24,
   localparam int REQ_WIDTH   = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
   localparam int RSP_WIDTH   = ((pr_cc_pkg::DutyWidth + SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  pr_cc_pkg::cmd_type                      cmd,
   output pr_cc_pkg::status_type                   status,
   input  logic [REQ_WIDTH-1:0]                    req_tdata,
   input  logic                                    csr_valid,
   input  logic [pr_cc_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [COEF_WIDTH-1:0]                   csr_data,
   input  logic                                    rsp_tready,
   output logic                                    rsp_tvalid,
   output logic [RSP_WIDTH-1:0]                    rsp_tdata
);
   import pr_cc_pkg::*;

   localparam int PROD_WIDTH = COEF_WIDTH + MulBWidth;
   localparam int ACC_WIDTH  = PROD_WIDTH + 6;
   localparam int TOT_WIDTH  = PROD_WIDTH + 1;
   localparam int ACC_TOP    = ResWidth + ResFracShift - 1;

   logic signed [COEF_WIDTH-1:0]   kp_ff;
   logic signed [COEF_WIDTH-1:0]   krg_ff;
   logic signed [COEF_WIDTH-1:0]   kfb_ff;
   logic signed [COEF_WIDTH-1:0]   kdc_ff;

   logic signed [SAMPLE_WIDTH-1:0] err_d1_ff;
   logic signed [SAMPLE_WIDTH-1:0] err_d2_ff;
   logic signed [ResWidth-1:0]     res_d1_ff;
   logic signed [ResWidth-1:0]     res_d2_ff;

   logic signed [SAMPLE_WIDTH-1:0] err_ff;
   logic signed [SAMPLE_WIDTH:0]   derr_ff;
   logic signed [SAMPLE_WIDTH-1:0] vg_ff;
   logic signed [PROD_WIDTH-1:0]   prod_ff;
   logic signed [ACC_WIDTH-1:0]    acc_ff;
   logic signed [TOT_WIDTH-1:0]    tot_ff;

   logic                           rsp_valid_ff;
   logic [DutyWidth-1:0]           rsp_duty_ff;
   logic [SAMPLE_WIDTH-1:0]        rsp_err_ff;

   logic signed [SAMPLE_WIDTH-1:0] cur_ref;
   logic signed [SAMPLE_WIDTH-1:0] cur_meas;
   logic signed [SAMPLE_WIDTH:0]   diff;
   logic signed [SAMPLE_WIDTH-1:0] err_in;
   logic signed [SAMPLE_WIDTH:0]   derr_in;
   logic signed [COEF_WIDTH-1:0]   mul_a;
   logic signed [MulBWidth-1:0]    mul_b;
   logic signed [PROD_WIDTH-1:0]   prod_in;
   logic                           res_ovf;
   logic signed [ResWidth-1:0]     vr;
   logic signed [PROD_WIDTH-1:0]   vp;
   logic signed [TOT_WIDTH-1:0]    tot_in;
   logic                           tot_ovf;
   logic signed [MulBWidth-1:0]    tot_clamp;
   logic                           duty_ovf;
   logic [DutyWidth-1:0]           duty;

   assign cur_ref  = req_tdata[SAMPLE_WIDTH-1:0];
   assign cur_meas = req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
   assign diff     = (SAMPLE_WIDTH+1)'(cur_ref) - (SAMPLE_WIDTH+1)'(cur_meas);
   assign err_in   = (diff[SAMPLE_WIDTH] != diff[SAMPLE_WIDTH-1])
                   ? {diff[SAMPLE_WIDTH], {(SAMPLE_WIDTH-1){~diff[SAMPLE_WIDTH]}}}
                   : diff[SAMPLE_WIDTH-1:0];
   assign derr_in  = (SAMPLE_WIDTH+1)'(err_in) - (SAMPLE_WIDTH+1)'(err_d2_ff);

   always_comb begin
      case (cmd.mul_op)
         MUL_RES_GAIN: begin
            mul_a = krg_ff;
            mul_b = MulBWidth'(derr_ff);
         end
         MUL_RES_FB: begin
            mul_a = kfb_ff;
            mul_b = MulBWidth'(res_d1_ff);
         end
         MUL_PROP: begin
            mul_a = kp_ff;
            mul_b = MulBWidth'(err_ff);
         end
         MUL_SCALE: begin
            mul_a = kdc_ff;
            mul_b = tot_clamp;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   assign res_ovf = !((&acc_ff[ACC_WIDTH-1:ACC_TOP]) || !(|acc_ff[ACC_WIDTH-1:ACC_TOP]));
   assign vr      = res_ovf
                  ? {acc_ff[ACC_WIDTH-1], {(ResWidth-1){~acc_ff[ACC_WIDTH-1]}}}
                  : acc_ff[ACC_TOP:ResFracShift];

   assign vp     = prod_ff >>> PropShift;
   assign tot_in = TOT_WIDTH'(vp) + TOT_WIDTH'(vr) + (TOT_WIDTH'(vg_ff) <<< InAlignShift);

   assign tot_ovf   = !((&tot_ff[TOT_WIDTH-1:MulBWidth-1])
                     || !(|tot_ff[TOT_WIDTH-1:MulBWidth-1]));
   assign tot_clamp = tot_ovf
                    ? {tot_ff[TOT_WIDTH-1], {(MulBWidth-1){~tot_ff[TOT_WIDTH-1]}}}
                    : tot_ff[MulBWidth-1:0];

   assign duty_ovf = !((&prod_ff[PROD_WIDTH-1:DutyShift+DutyWidth-1])
                    || !(|prod_ff[PROD_WIDTH-1:DutyShift+DutyWidth-1]));
   assign duty     = duty_ovf
                   ? {prod_ff[PROD_WIDTH-1], {(DutyWidth-1){~prod_ff[PROD_WIDTH-1]}}}
                   : prod_ff[DutyShift+DutyWidth-1:DutyShift];

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff  <= '0;
         krg_ff <= '0;
         kfb_ff <= '0;
         kdc_ff <= COEF_WIDTH'(KdcResetValue);
      end else if (csr_valid) begin
         case (csr_index)
            RegPropGain:    kp_ff  <= csr_data;
            RegResGain:     krg_ff <= csr_data;
            RegResFeedback: kfb_ff <= csr_data;
            RegOutputScale: kdc_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_d1_ff <= '0;
         err_d2_ff <= '0;
         res_d1_ff <= '0;
         res_d2_ff <= '0;
      end else if (cmd.res_update) begin
         err_d2_ff <= err_d1_ff;
         err_d1_ff <= err_ff;
         res_d2_ff <= res_d1_ff;
         res_d1_ff <= vr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         err_ff  <= err_in;
         derr_ff <= derr_in;
         vg_ff   <= req_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
      end
      if (cmd.mul_op != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_init) begin
         acc_ff <= (ACC_WIDTH'(prod_ff) <<< InAlignShift)
                 - (ACC_WIDTH'(res_d2_ff) <<< ResFracShift);
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + ACC_WIDTH'(prod_ff);
      end
      if (cmd.res_update) begin
         tot_ff <= tot_in;
      end
      if (cmd.out_load) begin
         rsp_duty_ff <= duty;
         rsp_err_ff  <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = RSP_WIDTH'({rsp_err_ff, rsp_duty_ff});

endmodule

[src/pr_cc_core_top.sv]
// Holds no design units; the top level is pr_current_controller_core.
`timescale 1ns / 1ps

[src/pr_current_controller_core.sv]
// A req transaction is taken only while the sequencer is idle, not before the last one
// is through, since the single shared multiplier forms four products in sequence.
// A finished result waits in the rsp register while the next transaction is taken.
// Reset: synchronous, active high; clears the sequencer, the error and resonant
// delay lines and the gains (output scale to 0.5).
`timescale 1ns / 1ps

module pr_current_controller_core #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 24,
   localparam int REQ_WIDTH   = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
   localparam int RSP_WIDTH   = ((pr_cc_pkg::DutyWidth + SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // current_ref, current_meas, grid_voltage
   input  logic [REQ_WIDTH-1:0]                req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // duty_ref, error_out
   output logic [RSP_WIDTH-1:0]                rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pr_cc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]               csr_data
);
   import pr_cc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   pr_cc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pr_cc_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted while a transaction is in progress");

   a_capture_starts_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.mul_op == MUL_RES_GAIN)
      else $error("capture not followed by resonant gain product");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("result load did not raise rsp_tvalid");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.acc_init, cmd.acc_add, cmd.res_update, cmd.out_load}))
      else $error("more than one datapath command in a cycle");
`endif

endmodule

[tb/pr_current_controller_core_tb.sv]
// Self-checking testbench of the proportional-resonant current controller core.
`timescale 1ns / 1ps

module pr_current_controller_core_tb;

   import pr_cc_pkg::*;

   localparam int SampleWidth = 16;
   localparam int CoefWidth   = 24;
   localparam longint ErrMax  = 64'sh7FFF;
   localparam longint ErrMin  = -ErrMax - 1;
   localparam longint ResMax  = 64'sh7FFF_FFFF;
   localparam longint ResMin  = -ResMax - 1;
   localparam longint DutyMax = 64'sh7FFF;
   localparam longint DutyMin = -DutyMax - 1;
   localparam logic [CoefWidth-1:0] CoefMax = 24'h7F_FFFF;
   localparam logic [CoefWidth-1:0] CoefMin = 24'h80_0000;

   typedef struct packed {
      logic [SampleWidth-1:0] error;
      logic [DutyWidth-1:0]   duty;
   } duty_error_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CoefWidth-1:0] csr_data = '0;

   logic [47:0] sample_q[$];
   duty_error_type duty_error_q[$];
   int mismatch_count = 0;
   int pending = 0;
   int req_wait = 0;
   int rsp_wait = 0;
   bit idle_on = 1'b1;

   // controller image: gains and delay lines
   longint kp_gain = 0;
   longint kr_gain = 0;
   longint k2_gain = 0;
   longint kdc_gain = KdcResetValue;
   longint err_d1 = 0;
   longint err_d2 = 0;
   longint res_d1 = 0;
   longint res_d2 = 0;

   pr_current_controller_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   function automatic int draw_wait();
      return idle_on ? $urandom_range(0, 3) : 0;
   endfunction

   function automatic duty_error_type predict_duty(input logic [47:0] sample);
      longint i_ref, i_meas, v_grid, err, acc, vres, total, duty;
      duty_error_type result;
      i_ref  = longint'($signed(sample[15:0]));
      i_meas = longint'($signed(sample[31:16]));
      v_grid = longint'($signed(sample[47:32]));
      err = i_ref - i_meas;
      if (err > ErrMax) err = ErrMax;
      else if (err < ErrMin) err = ErrMin;
      acc = kr_gain * (err - err_d2) * 16 + k2_gain * res_d1 - res_d2 * 65536;
      vres = acc >>> 16;
      if (vres > ResMax) vres = ResMax;
      else if (vres < ResMin) vres = ResMin;
      err_d2 = err_d1;
      err_d1 = err;
      res_d2 = res_d1;
      res_d1 = vres;
      total = ((kp_gain * err) >>> 12) + vres + v_grid * 16;
      duty = (total * kdc_gain) >>> 17;
      if (duty > DutyMax) duty = DutyMax;
      else if (duty < DutyMin) duty = DutyMin;
      result.duty  = duty[15:0];
      result.error = err[15:0];
      return result;
   endfunction

   task automatic flag_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
      if (want !== got) begin
         if (mismatch_count < 10)
            $display("%0t: %s expected %0d got %0d", $time, field,
                     $signed(want), $signed(got));
         mismatch_count++;
      end
   endtask

   // req side: hold each sample until taken, then idle for the drawn gap
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_wait <= 0;
      end else begin
         if (req_tvalid && req_tready)
            duty_error_q.push_back(predict_duty(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (req_wait > 0) begin
               req_wait <= req_wait - 1;
               req_tvalid <= 1'b0;
            end else if (sample_q.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= sample_q.pop_front();
               req_wait <= draw_wait();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // rsp side: check each transaction, then stall for the drawn count
   always @(posedge clock) begin : rsp_side
      int hold;
      duty_error_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (duty_error_q.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: unexpected rsp transaction %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = duty_error_q.pop_front();
            flag_field("duty_ref", want.duty, rsp_tdata[15:0]);
            flag_field("error_out", want.error, rsp_tdata[31:16]);
            pending--;
         end
         hold = draw_wait();
         rsp_tready <= (hold == 0);
         rsp_wait <= hold;
      end else if (!rsp_tready) begin
         if (rsp_wait <= 1)
            rsp_tready <= 1'b1;
         rsp_wait <= rsp_wait - 1;
      end
   end

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CoefWidth-1:0] value);
      longint coef;
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      coef = longint'($signed(value));
      case (idx)
         RegPropGain:    kp_gain = coef;
         RegResGain:     kr_gain = coef;
         RegResFeedback: k2_gain = coef;
         RegOutputScale: kdc_gain = coef;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic push_sample(input logic [15:0] i_ref, input logic [15:0] i_meas,
                              input logic [15:0] v_grid);
      sample_q.push_back({v_grid, i_meas, i_ref});
      pending++;
   endtask

   // hold until every pushed sample has come back as a checked rsp transaction
   task automatic wait_drained();
      while (pending != 0)
         @(posedge clock);
   endtask

   function automatic logic [15:0] draw_sample();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 12) return 16'($urandom);
      if (pick < 17) return 16'($urandom_range(0, 4095) - 2048);
      case ($urandom_range(0, 3))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic logic [CoefWidth-1:0] draw_coef();
      case ($urandom_range(0, 6))
         0: return CoefMax;
         1: return CoefMin;
         2: return '0;
         3: return 24'h01_0000;
         4: return 24'($urandom);
         default: return 24'($urandom_range(0, 262143) - 131072);
      endcase
   endfunction

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset gains: error saturation and the output clamp at plus and minus one
      push_sample(16'h0000, 16'h0000, 16'h0000);
      push_sample(16'h7FFF, 16'h8000, 16'h0000);
      push_sample(16'h8000, 16'h7FFF, 16'h0000);
      push_sample(16'h0000, 16'h0000, 16'd4096);
      push_sample(16'h0000, 16'h0000, -16'sd4096);
      push_sample(16'h0000, 16'h0000, 16'd4095);
      push_sample(16'h0000, 16'h0000, 16'h7FFF);
      push_sample(16'h0000, 16'h0000, 16'h8000);
      push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
      wait_drained();

      // largest gains: drive the resonator into saturation; drop out-of-range writes
      write_reg(RegPropGain, CoefMax);
      write_reg(RegResGain, CoefMax);
      write_reg(RegResFeedback, CoefMax);
      write_reg(RegOutputScale, CoefMax);
      write_reg(CsrIndexWidth'(4), 24'h00_0000);
      write_reg(CsrIndexWidth'(255), 24'hFF_FFFF);
      repeat (3) begin
         push_sample(16'h7FFF, 16'h8000, 16'h7FFF);
         push_sample(16'h8000, 16'h7FFF, 16'h8000);
      end
      wait_drained();

      // most negative gains
      write_reg(RegPropGain, CoefMin);
      write_reg(RegResGain, CoefMin);
      write_reg(RegResFeedback, CoefMin);
      write_reg(RegOutputScale, CoefMin);
      repeat (3) begin
         push_sample(16'h8000, 16'h7FFF, 16'h8000);
         push_sample(16'h7FFF, 16'h8000, 16'h7FFF);
      end
      wait_drained();

      for (int phase = 0; phase < 10; phase++) begin
         idle_on = (phase % 3 != 1);
         if (phase % 4 == 3)
            write_reg(CsrIndexWidth'($urandom_range(4, 255)), 24'($urandom));
         write_reg(RegPropGain, draw_coef());
         write_reg(RegResGain, draw_coef());
         write_reg(RegResFeedback, draw_coef());
         write_reg(RegOutputScale, draw_coef());
         for (int n = 0; n < 115; n++)
            push_sample(draw_sample(), draw_sample(), draw_sample());
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && duty_error_q.size() == 0) begin
         $display("[pr_current_controller_core] OK");
      end else begin
         $display("[pr_current_controller_core] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("[pr_current_controller_core] ERROR");
      $finish;
   end

endmodule

[sim.f]
src/pr_cc_pkg.sv
src/pr_cc_ctrl.sv
src/pr_cc_dp.sv
src/pr_cc_core_top.sv
src/pr_current_controller_core.sv
tb/pr_current_controller_core_tb.sv
